// ===== hw/rtl/clc_pkg.sv =====
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types, request codes and constants of the character display
// controller.
// ----------------------------------------------------------------------------
package clc_pkg;

	localparam int DEF_SCREEN_BYTES = 128;
	localparam int RAM_DEPTH        = 256;
	localparam int ADDR_W           = 8;
	localparam int DATA_W           = 8;

	localparam logic [3:0]        BLINK_TICKS  = 4'd10;
	localparam logic [DATA_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [DATA_W-1:0] GLYPH_MASK   = 8'h1F;
	localparam logic [DATA_W-1:0] CTRL_RD_MASK = 8'h7F;
	localparam logic [DATA_W-1:0] CMD_CLEAR    = 8'h01;
	localparam logic [ADDR_W-1:0] GLYPH_BASE   = 8'h80;

	localparam logic [2:0] REQ_CTRL_WR = 3'd0;
	localparam logic [2:0] REQ_CTRL_RD = 3'd1;
	localparam logic [2:0] REQ_DATA_WR = 3'd2;
	localparam logic [2:0] REQ_DATA_RD = 3'd3;
	localparam logic [2:0] REQ_TICK    = 3'd4;
	localparam logic [2:0] REQ_PWR_ON  = 3'd5;
	localparam logic [2:0] REQ_PWR_OFF = 3'd6;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [DATA_W-1:0] value;
	} clc_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [ADDR_W-1:0] address;
		logic              cursor_phase;
		logic              underline_on;
		logic              block_on;
		logic              powered;
	} clc_rsp_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic fill;
		logic load_out;
	} clc_cmd_t;

	typedef struct packed {
		logic need_fill;
		logic fill_last;
	} clc_sts_t;

endpackage

// ===== hw/rtl/char_lcd_controller.sv =====
// ----------------------------------------------------------------------------
// char_lcd_controller
// Character display controller with a character and user-glyph RAM,
// address counter, cursor enables, blink phase and power control.
//
//   Channel  Signals                          Payload
//   request  req_valid / req_ready / req      clc_req_t (req_type, value)
//   result   rsp_valid / rsp_ready / rsp      clc_rsp_t (read_data .. powered)
//
// A request is accepted in the idle state and executed in the execute state.
// A clear command or a power-on request adds a fill sweep of SCREEN_BYTES
// RAM writes, one RAM write per cycle, and a wait step to load the result,
// during which no request is accepted.
// Reset clears control state; per-entry valid bits make the RAM read as zero.
// A new request is accepted while the previous result waits on rsp_ready.
// ----------------------------------------------------------------------------
module char_lcd_controller import clc_pkg::*; #(
	parameter int SCREEN_BYTES = DEF_SCREEN_BYTES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  clc_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output clc_rsp_t rsp
);

	clc_cmd_t cmd;
	clc_sts_t sts;

	clc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	clc_dp #(
		.SCREEN_BYTES (SCREEN_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while the previous one is still executing");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without an executing request");

	a_single_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.exec, cmd.fill, cmd.load_out && !cmd.exec}))
		else $error("conflicting sequencer commands");

endmodule

// ===== hw/rtl/clc_ram.sv =====
// ----------------------------------------------------------------------------
// clc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module clc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/clc_ctrl.sv =====
// ----------------------------------------------------------------------------
// clc_ctrl
// Sequencer of the controller: accepts a request, runs its execute step,
// sweeps a screen fill when needed and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module clc_ctrl import clc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  clc_sts_t sts,
	output clc_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       rsp_valid_q;
	logic       slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.need_fill) begin
					state_nxt = ST_FILL;
				end else if (slot_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end else begin
					state_nxt = ST_WAIT;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/clc_dp.sv =====
// ----------------------------------------------------------------------------
// clc_dp
// Datapath of the controller: request register, address counter, cursor
// and blink state, character RAM with per-entry valid bits, fill counter
// and the result register.
// ----------------------------------------------------------------------------
module clc_dp import clc_pkg::*; #(
	parameter int SCREEN_BYTES = DEF_SCREEN_BYTES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  clc_req_t req,
	output clc_rsp_t rsp,
	input  clc_cmd_t cmd,
	output clc_sts_t sts
);

	localparam int FILL_W = $clog2(SCREEN_BYTES);

	clc_req_t          req_q;
	clc_rsp_t          rsp_q;
	logic [ADDR_W-1:0] addr_q;
	logic              down_q;
	logic              ul_q;
	logic              bk_q;
	logic              phase_q;
	logic [3:0]        tick_q;
	logic              pwr_q;
	logic [DATA_W-1:0] rd_q;
	logic [FILL_W-1:0] fill_q;
	logic [RAM_DEPTH-1:0] vld_q;
	logic              vld_rd_q;

	logic [ADDR_W-1:0] nxt_addr;
	logic              nxt_down;
	logic              nxt_ul;
	logic              nxt_bk;
	logic              nxt_phase;
	logic [3:0]        nxt_tick;
	logic              nxt_pwr;
	logic [DATA_W-1:0] nxt_rd;
	logic [DATA_W-1:0] rd_comb;
	logic [ADDR_W-1:0] step_addr;
	logic [3:0]        tick_inc;
	logic              clr_vld;
	logic              item_we;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] mem_rd;

	clc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign mem_rd    = vld_rd_q ? ram_rdata : '0;
	assign step_addr = down_q ? (addr_q - 8'd1) : (addr_q + 8'd1);
	assign tick_inc  = tick_q + 4'd1;

	assign ram_we    = cmd.fill || item_we;
	assign ram_waddr = cmd.fill ? ADDR_W'(fill_q) : addr_q;
	assign ram_wdata = cmd.fill ? SPACE_CHAR
		: (addr_q[ADDR_W-1] ? (req_q.value & GLYPH_MASK) : req_q.value);

	assign sts.need_fill = (req_q.req_type == REQ_PWR_ON)
		|| ((req_q.req_type == REQ_CTRL_WR) && pwr_q && (req_q.value == CMD_CLEAR));
	assign sts.fill_last = (fill_q == FILL_W'(SCREEN_BYTES - 1));

	always_comb begin
		nxt_addr  = addr_q;
		nxt_down  = down_q;
		nxt_ul    = ul_q;
		nxt_bk    = bk_q;
		nxt_phase = phase_q;
		nxt_tick  = tick_q;
		nxt_pwr   = pwr_q;
		rd_comb   = '0;
		clr_vld   = 1'b0;
		item_we   = 1'b0;
		if (cmd.exec) begin
			case (req_q.req_type)
				REQ_CTRL_WR: begin
					if (pwr_q) begin
						if (req_q.value inside {[8'd0:8'd3]}) begin
							nxt_addr = '0;
						end else if (req_q.value inside {[8'd4:8'd7]}) begin
							nxt_down = !req_q.value[1];
						end else if (req_q.value inside {[8'd8:8'd15]}) begin
							nxt_ul = req_q.value[1];
							nxt_bk = req_q.value[0];
						end else if (req_q.value inside {[8'd16:8'd31]}) begin
							if (!req_q.value[3]) begin
								nxt_addr = req_q.value[2] ? (addr_q - 8'd1) : (addr_q + 8'd1);
							end
						end else if (req_q.value inside {[8'd64:8'd127]}) begin
							nxt_addr = GLYPH_BASE | {2'b00, req_q.value[5:0]};
						end else if (req_q.value[7]) begin
							nxt_addr = {1'b0, req_q.value[6:0]};
						end
					end
				end
				REQ_CTRL_RD: begin
					rd_comb = addr_q & CTRL_RD_MASK;
				end
				REQ_DATA_WR: begin
					if (pwr_q) begin
						item_we  = 1'b1;
						nxt_addr = step_addr;
					end
				end
				REQ_DATA_RD: begin
					rd_comb  = mem_rd;
					nxt_addr = step_addr;
				end
				REQ_TICK: begin
					if (pwr_q) begin
						if (tick_inc >= BLINK_TICKS) begin
							nxt_tick  = '0;
							nxt_phase = !phase_q;
						end else begin
							nxt_tick = tick_inc;
						end
					end
				end
				REQ_PWR_ON: begin
					nxt_pwr   = 1'b1;
					clr_vld   = 1'b1;
					nxt_addr  = '0;
					nxt_down  = 1'b0;
					nxt_phase = 1'b0;
					nxt_ul    = 1'b0;
					nxt_bk    = 1'b0;
				end
				REQ_PWR_OFF: begin
					nxt_pwr = 1'b0;
				end
				default: begin
				end
			endcase
		end
		nxt_rd = cmd.exec ? rd_comb : rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			down_q   <= 1'b0;
			ul_q     <= 1'b0;
			bk_q     <= 1'b0;
			phase_q  <= 1'b0;
			tick_q   <= '0;
			pwr_q    <= 1'b0;
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			addr_q   <= nxt_addr;
			down_q   <= nxt_down;
			ul_q     <= nxt_ul;
			bk_q     <= nxt_bk;
			phase_q  <= nxt_phase;
			tick_q   <= nxt_tick;
			pwr_q    <= nxt_pwr;
			vld_rd_q <= vld_q[addr_q];
			if (clr_vld) begin
				vld_q <= '0;
			end else if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (cmd.exec) begin
				fill_q <= '0;
			end else if (cmd.fill) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			rd_q <= rd_comb;
		end
		if (cmd.load_out) begin
			rsp_q.read_data    <= nxt_rd;
			rsp_q.address      <= nxt_addr;
			rsp_q.cursor_phase <= nxt_phase;
			rsp_q.underline_on <= nxt_ul;
			rsp_q.block_on     <= nxt_bk;
			rsp_q.powered      <= nxt_pwr;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== tb/tb_char_lcd_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_controller
// Self-checking testbench for the character display controller. A shadow
// copy of the display state predicts one result for every accepted request
// and checks the results in order, field by field. The run starts with a
// short directed sequence and continues with random bus traffic. Both
// handshakes stall at random, and at one point the result side holds off
// long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_char_lcd_controller;
	import clc_pkg::*;

	localparam logic [2:0] REQ_UNUSED = 3'd7;

	localparam logic [7:0] CMD_DIR_BASE    = 8'h04;
	localparam logic [7:0] CMD_CURSOR_BASE = 8'h08;
	localparam logic [7:0] CMD_MOVE_BASE   = 8'h10;
	localparam logic [7:0] CMD_NOP_BASE    = 8'h20;
	localparam logic [7:0] CMD_GLYPH_ADDR  = 8'h40;
	localparam logic [7:0] CMD_DISP_ADDR   = 8'h80;
	localparam logic [7:0] GLYPH_ADDR_MASK = 8'h3F;
	localparam logic [7:0] DISP_ADDR_MASK  = 8'h7F;

	localparam int RANDOM_ITEMS = 820;
	localparam int HOLD_AT      = 300;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 300;
	// Watchdog timeout in nanoseconds, several times the slowest legal run.
	localparam int TIMEOUT_NS   = 20_000_000;

	class lcd_shadow;
		logic [7:0] char_mem [RAM_DEPTH] = '{default: '0};
		logic [7:0] addr         = '0;
		logic       step_down    = 1'b0;
		logic       underline_en = 1'b0;
		logic       block_en     = 1'b0;
		logic       blink_phase  = 1'b0;
		logic [3:0] tick_cnt     = '0;
		logic       power_on     = 1'b0;
		clc_rsp_t   expected_rsps [$];
		int unsigned noted      = 0;
		int unsigned mismatches = 0;

		function void fill_screen();
			for (int i = 0; i < DEF_SCREEN_BYTES; i++)
				char_mem[i] = SPACE_CHAR;
		endfunction

		function void step_addr();
			addr = step_down ? addr - 8'd1 : addr + 8'd1;
		endfunction

		function void run_command(logic [7:0] v);
			if (v == CMD_CLEAR) begin
				fill_screen();
				addr = '0;
			end else if (v < CMD_DIR_BASE) begin
				addr = '0;
			end else if (v < CMD_CURSOR_BASE) begin
				step_down = ~v[1];
			end else if (v < CMD_MOVE_BASE) begin
				underline_en = v[1];
				block_en     = v[0];
			end else if (v < CMD_NOP_BASE) begin
				if (!v[3])
					addr = v[2] ? addr - 8'd1 : addr + 8'd1;
			end else if (v >= CMD_DISP_ADDR) begin
				addr = v & DISP_ADDR_MASK;
			end else if (v >= CMD_GLYPH_ADDR) begin
				addr = GLYPH_BASE | (v & GLYPH_ADDR_MASK);
			end
		endfunction

		function void note_request(clc_req_t item);
			clc_rsp_t r;
			r = '0;
			case (item.req_type)
				REQ_CTRL_WR: begin
					if (power_on)
						run_command(item.value);
				end
				REQ_CTRL_RD: begin
					r.read_data = addr & CTRL_RD_MASK;
				end
				REQ_DATA_WR: begin
					if (power_on) begin
						char_mem[addr] = addr[7] ? item.value & GLYPH_MASK : item.value;
						step_addr();
					end
				end
				REQ_DATA_RD: begin
					r.read_data = char_mem[addr];
					step_addr();
				end
				REQ_TICK: begin
					if (power_on) begin
						tick_cnt = tick_cnt + 4'd1;
						if (tick_cnt >= BLINK_TICKS) begin
							tick_cnt    = '0;
							blink_phase = ~blink_phase;
						end
					end
				end
				REQ_PWR_ON: begin
					power_on = 1'b1;
					foreach (char_mem[i])
						char_mem[i] = '0;
					fill_screen();
					addr         = '0;
					step_down    = 1'b0;
					blink_phase  = 1'b0;
					underline_en = 1'b0;
					block_en     = 1'b0;
				end
				REQ_PWR_OFF: begin
					power_on = 1'b0;
				end
				default: begin
				end
			endcase
			r.address      = addr;
			r.cursor_phase = blink_phase;
			r.underline_on = underline_en;
			r.block_on     = block_en;
			r.powered      = power_on;
			expected_rsps.push_back(r);
			noted++;
		endfunction

		task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
			mismatches++;
			$display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
		endtask

		task check_response(clc_rsp_t got);
			clc_rsp_t want;
			if (expected_rsps.size() == 0) begin
				report_mismatch("result without request, address", got.address, 8'h00);
				return;
			end
			want = expected_rsps.pop_front();
			if (got.read_data !== want.read_data)
				report_mismatch("read_data", got.read_data, want.read_data);
			if (got.address !== want.address)
				report_mismatch("address", got.address, want.address);
			if (got.cursor_phase !== want.cursor_phase)
				report_mismatch("cursor_phase", 8'(got.cursor_phase),
					8'(want.cursor_phase));
			if (got.underline_on !== want.underline_on)
				report_mismatch("underline_on", 8'(got.underline_on),
					8'(want.underline_on));
			if (got.block_on !== want.block_on)
				report_mismatch("block_on", 8'(got.block_on), 8'(want.block_on));
			if (got.powered !== want.powered)
				report_mismatch("powered", 8'(got.powered), 8'(want.powered));
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	clc_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	clc_rsp_t rsp;

	lcd_shadow shadow = new;

	char_lcd_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		else if (roll < 88)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			req_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_request(input clc_req_t item);
		req_valid <= 1'b1;
		req       <= item;
		do begin
			@(posedge clk);
		end while (!req_ready);
		shadow.note_request(item);
	endtask

	initial begin : stimulus
		clc_req_t    opening [$];
		clc_req_t    item;
		int unsigned roll;
		int unsigned cls;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Power is off first: reads still work, writes and ticks are dropped.
		opening = '{
			'{REQ_DATA_RD, 8'hFF}, '{REQ_CTRL_RD, 8'h00}, '{REQ_DATA_WR, 8'hAA},
			'{REQ_TICK, 8'h00}, '{REQ_CTRL_WR, 8'hC5}, '{REQ_UNUSED, 8'h5A},
			'{REQ_PWR_ON, 8'h00}, '{REQ_CTRL_WR, 8'h0F}, '{REQ_CTRL_WR, 8'h05},
			'{REQ_DATA_WR, 8'hFF}, '{REQ_DATA_WR, 8'hFF}, '{REQ_CTRL_WR, 8'h06},
			'{REQ_CTRL_WR, 8'h14}, '{REQ_CTRL_WR, 8'h18}, '{REQ_DATA_WR, 8'h00},
			'{REQ_DATA_RD, 8'h00}, '{REQ_DATA_RD, 8'h00}, '{REQ_CTRL_WR, 8'h7F},
			'{REQ_CTRL_WR, 8'hFF}, '{REQ_CTRL_RD, 8'h00}, '{REQ_CTRL_WR, CMD_CLEAR}
		};
		repeat (10) opening.push_back('{REQ_TICK, 8'h00});
		opening.push_back('{REQ_PWR_OFF, 8'h00});
		opening.push_back('{REQ_DATA_RD, 8'h00});
		foreach (opening[i]) begin
			pause_sender(pick_gap());
			send_request(opening[i]);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll       = $urandom_range(0, 99);
			item.value = 8'($urandom_range(0, 255));
			if (!shadow.power_on && roll < 30) begin
				item.req_type = REQ_PWR_ON;
			end else if (roll < 28) begin
				item.req_type = REQ_CTRL_WR;
				cls = $urandom_range(0, 7);
				case (cls)
					0: item.value = 8'($urandom_range(0, 3));
					1: item.value = CMD_DIR_BASE + 8'($urandom_range(0, 3));
					2: item.value = CMD_CURSOR_BASE + 8'($urandom_range(0, 7));
					3: item.value = CMD_MOVE_BASE + 8'($urandom_range(0, 15));
					4: item.value = CMD_NOP_BASE + 8'($urandom_range(0, 31));
					5: item.value = CMD_GLYPH_ADDR + 8'($urandom_range(0, 63));
					default: item.value = CMD_DISP_ADDR + 8'($urandom_range(0, 127));
				endcase
			end else if (roll < 36) begin
				item.req_type = REQ_CTRL_RD;
			end else if (roll < 66) begin
				item.req_type = REQ_DATA_WR;
			end else if (roll < 84) begin
				item.req_type = REQ_DATA_RD;
			end else if (roll < 96) begin
				item.req_type = REQ_TICK;
			end else if (roll < 97) begin
				item.req_type = REQ_PWR_ON;
			end else if (roll < 98) begin
				item.req_type = REQ_PWR_OFF;
			end else begin
				item.req_type = REQ_UNUSED;
			end
			if ((n / 60) % 4 != 1)
				pause_sender(pick_gap());
			send_request(item);
		end
		req_valid <= 1'b0;

		while (shadow.expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : result_side
		int unsigned run_left;
		int unsigned roll;
		bit          hold_done;
		run_left  = 0;
		hold_done = 1'b0;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				shadow.check_response(rsp);
			if (run_left != 0) begin
				run_left--;
			end else if (!hold_done && shadow.noted >= HOLD_AT) begin
				// Stall long enough for the request side to back up.
				hold_done = 1'b1;
				run_left  = LONG_HOLD;
				rsp_ready <= 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					run_left = $urandom_range(1, 16);
					rsp_ready <= 1'b1;
				end else if (roll < 70) begin
					run_left = $urandom_range(50, 150);
					rsp_ready <= 1'b1;
				end else if (roll < 95) begin
					run_left = $urandom_range(1, 4);
					rsp_ready <= 1'b0;
				end else begin
					run_left = $urandom_range(10, 40);
					rsp_ready <= 1'b0;
				end
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule
